### rtl/cstt_pkg.sv
`default_nettype none
package cstt_pkg;

   // default table size
   localparam int MAX_SLOTS_DEF = 64;

   // id layout
   localparam int PREFIX_SHIFT = 24;
   localparam int PREFIX_W     = 8;
   localparam int INDEX_W      = 24;

   // input function codes
   localparam logic [2:0] FUNC_ADD     = 3'd0;
   localparam logic [2:0] FUNC_DELETE  = 3'd1;
   localparam logic [2:0] FUNC_REFRESH = 3'd2;
   localparam logic [2:0] FUNC_GET     = 3'd3;
   localparam logic [2:0] FUNC_CHECK   = 3'd4;

   // result status codes
   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_FULL   = 3'd1;
   localparam logic [2:0] STAT_PREFIX = 3'd2;
   localparam logic [2:0] STAT_RANGE  = 3'd3;
   localparam logic [2:0] STAT_UNUSED = 3'd4;

   // classified operation
   typedef enum logic [2:0] {
      OP_ADD,
      OP_DEL,
      OP_REF,
      OP_GET,
      OP_CHK,
      OP_NOP
   } op_type;

   // command passed from the front to the back
   typedef struct packed {
      op_type      op;
      logic [31:0] handle;
      logic [31:0] id;
      logic [31:0] tmo;
      logic [31:0] now;
   } cmd_type;

   // back sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_GET_WR,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

endpackage
`default_nettype wire

### rtl/cstt_front.sv
`default_nettype none
module cstt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [127:0]      req_tdata,
   input  wire logic [2:0]        req_tuser,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output cstt_pkg::cmd_type      cmd
);

   cstt_pkg::cmd_type q_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   cstt_pkg::cmd_type dec;
   logic              push, pop;

   // classify the function code
   always_comb begin
      dec.handle = req_tdata[31:0];
      dec.id     = req_tdata[63:32];
      dec.tmo    = req_tdata[95:64];
      dec.now    = req_tdata[127:96];
      unique case (req_tuser)
         cstt_pkg::FUNC_ADD:     dec.op = cstt_pkg::OP_ADD;
         cstt_pkg::FUNC_DELETE:  dec.op = cstt_pkg::OP_DEL;
         cstt_pkg::FUNC_REFRESH: dec.op = cstt_pkg::OP_REF;
         cstt_pkg::FUNC_GET:     dec.op = cstt_pkg::OP_GET;
         cstt_pkg::FUNC_CHECK:   dec.op = cstt_pkg::OP_CHK;
         default:                dec.op = cstt_pkg::OP_NOP;
      endcase
   end

   // two-entry command queue
   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;
   assign wr_in      = push ? ~wr_ff : wr_ff;
   assign rd_in      = pop ? ~rd_ff : rd_ff;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/cstt_back.sv
`default_nettype none
module cstt_back #(
   parameter int MAX_SLOTS = cstt_pkg::MAX_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        prefix,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire cstt_pkg::cmd_type cmd,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [71:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   localparam int W  = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);

   // slot memories
   logic [31:0]  hmem [MAX_SLOTS];
   logic [31:0]  emem [MAX_SLOTS];
   logic [31:0]  smem [MAX_SLOTS];
   logic [W-1:0] qmem [MAX_SLOTS];
   logic [31:0]  h_rd_ff, e_rd_ff, s_rd_ff;
   logic [W-1:0] q_rd_ff;

   cstt_pkg::state_type state_ff, state_in;
   cstt_pkg::cmd_type   cmd_ff;
   logic [W-1:0]        head_ff, tail_ff;
   logic [CW-1:0]       nfree_ff;
   logic [31:0]         arm_ff;
   logic [MAX_SLOTS-1:0] used_ff, qval_ff;

   // scan registers
   logic [CW-1:0] scnt_ff;
   logic          dval_ff, found_ff, pend_ff;
   logic [W-1:0]  didx_ff, best_ff, pidx_ff;
   logic [31:0]   bexp_ff, bkey_ff, bhand_ff, phand_ff;

   // result register
   logic         ovalid_ff;
   logic [2:0]   ostat_ff;
   logic [31:0]  oid_ff, ohand_ff;
   logic         oexp_ff, olast_ff;

   logic         can_emit;
   logic [2:0]   chk_stat;
   logic [W-1:0] cidx;
   logic [W-1:0] add_idx;
   logic [31:0]  key;
   logic         hit;

   // control
   logic         pop, emit, e_exp, e_last;
   logic [2:0]   e_stat;
   logic [31:0]  e_id, e_hand;
   logic         h_we, h_re, x_we, x_re, q_re, rel, add_do;
   logic [W-1:0] h_ra, x_a, rel_idx;
   logic [31:0]  x_wd;
   logic         scan_start, scan_issue, pend_load, pend_clr;

   assign can_emit = !ovalid_ff || rsp_tready;
   assign cidx     = cmd.id[W-1:0];
   assign add_idx  = qval_ff[head_ff] ? q_rd_ff : head_ff;
   assign key      = s_rd_ff - arm_ff;
   assign hit      = dval_ff && used_ff[didx_ff] && (e_rd_ff <= cmd_ff.now) &&
                     (!found_ff || (e_rd_ff < bexp_ff) ||
                      ((e_rd_ff == bexp_ff) && (key < bkey_ff)));

   // id checks for delete, refresh and get
   always_comb begin
      priority if (cmd.id[31:24] != prefix) begin
         chk_stat = cstt_pkg::STAT_PREFIX;
      end else if (cmd.id[23:0] >= 24'(MAX_SLOTS)) begin
         chk_stat = cstt_pkg::STAT_RANGE;
      end else if (!used_ff[cidx]) begin
         chk_stat = cstt_pkg::STAT_UNUSED;
      end else begin
         chk_stat = cstt_pkg::STAT_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cstt_pkg::ST_IDLE: begin
            if (cmd_valid && can_emit) begin
               unique case (cmd.op)
                  cstt_pkg::OP_ADD: begin
                     if (nfree_ff != '0) state_in = cstt_pkg::ST_ADD_WR;
                  end
                  cstt_pkg::OP_GET: begin
                     if (chk_stat == cstt_pkg::STAT_OK) state_in = cstt_pkg::ST_GET_WR;
                  end
                  cstt_pkg::OP_CHK: state_in = cstt_pkg::ST_SCAN;
                  default: state_in = cstt_pkg::ST_IDLE;
               endcase
            end
         end
         cstt_pkg::ST_ADD_WR, cstt_pkg::ST_GET_WR: begin
            if (can_emit) state_in = cstt_pkg::ST_IDLE;
         end
         cstt_pkg::ST_SCAN: begin
            if ((scnt_ff == CW'(MAX_SLOTS)) && !dval_ff) state_in = cstt_pkg::ST_SCAN_END;
         end
         cstt_pkg::ST_SCAN_END: begin
            if (can_emit) state_in = found_ff ? cstt_pkg::ST_SCAN : cstt_pkg::ST_IDLE;
         end
         default: state_in = cstt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      e_stat     = cstt_pkg::STAT_OK;
      e_id       = '0;
      e_hand     = '0;
      e_exp      = 1'b0;
      e_last     = 1'b1;
      h_we       = 1'b0;
      h_re       = 1'b0;
      h_ra       = cidx;
      x_we       = 1'b0;
      x_re       = 1'b0;
      x_a        = cidx;
      x_wd       = cmd.now + cmd.tmo;
      q_re       = 1'b0;
      rel        = 1'b0;
      rel_idx    = cidx;
      add_do     = 1'b0;
      scan_start = 1'b0;
      scan_issue = 1'b0;
      pend_load  = 1'b0;
      pend_clr   = 1'b0;
      unique case (state_ff)
         cstt_pkg::ST_IDLE: begin
            if (cmd_valid && can_emit) begin
               pop = 1'b1;
               unique case (cmd.op)
                  cstt_pkg::OP_ADD: begin
                     if (nfree_ff == '0) begin
                        emit   = 1'b1;
                        e_stat = cstt_pkg::STAT_FULL;
                     end else begin
                        q_re = 1'b1;
                     end
                  end
                  cstt_pkg::OP_DEL, cstt_pkg::OP_REF, cstt_pkg::OP_GET: begin
                     if (chk_stat != cstt_pkg::STAT_OK) begin
                        emit   = 1'b1;
                        e_stat = chk_stat;
                     end else if (cmd.op == cstt_pkg::OP_DEL) begin
                        emit = 1'b1;
                        rel  = 1'b1;
                     end else if (cmd.op == cstt_pkg::OP_REF) begin
                        emit = 1'b1;
                        x_we = 1'b1;
                     end else begin
                        h_re = 1'b1;
                     end
                  end
                  cstt_pkg::OP_CHK: begin
                     scan_start = 1'b1;
                     pend_clr   = 1'b1;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         cstt_pkg::ST_ADD_WR: begin
            x_a  = add_idx;
            x_wd = cmd_ff.now + cmd_ff.tmo;
            if (can_emit) begin
               emit   = 1'b1;
               e_id   = {prefix, 24'(add_idx)};
               add_do = 1'b1;
               h_we   = 1'b1;
               x_we   = 1'b1;
            end
         end
         cstt_pkg::ST_GET_WR: begin
            if (can_emit) begin
               emit   = 1'b1;
               e_hand = h_rd_ff;
            end
         end
         cstt_pkg::ST_SCAN: begin
            h_ra = scnt_ff[W-1:0];
            x_a  = scnt_ff[W-1:0];
            if (scnt_ff != CW'(MAX_SLOTS)) begin
               scan_issue = 1'b1;
               h_re       = 1'b1;
               x_re       = 1'b1;
            end
         end
         cstt_pkg::ST_SCAN_END: begin
            rel_idx = best_ff;
            if (can_emit) begin
               e_id   = {prefix, 24'(pidx_ff)};
               e_hand = phand_ff;
               e_exp  = pend_ff;
               if (found_ff) begin
                  rel        = 1'b1;
                  emit       = pend_ff;
                  e_last     = 1'b0;
                  pend_load  = 1'b1;
                  scan_start = 1'b1;
               end else begin
                  emit     = 1'b1;
                  pend_clr = 1'b1;
                  if (!pend_ff) begin
                     e_id   = '0;
                     e_hand = '0;
                  end
               end
            end
         end
         default: pop = 1'b0;
      endcase
   end

   assign cmd_ready = pop;

   // memories
   always_ff @(posedge clock) begin
      if (h_we) hmem[add_idx] <= cmd_ff.handle;
      if (h_re) h_rd_ff <= hmem[h_ra];
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         emem[x_a] <= x_wd;
         smem[x_a] <= arm_ff;
      end
      if (x_re) begin
         e_rd_ff <= emem[x_a];
         s_rd_ff <= smem[x_a];
      end
   end

   always_ff @(posedge clock) begin
      if (rel) qmem[tail_ff] <= rel_idx;
      if (q_re) q_rd_ff <= qmem[head_ff];
   end

   // table control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cstt_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         nfree_ff <= CW'(MAX_SLOTS);
         arm_ff   <= '0;
         used_ff  <= '0;
         qval_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (x_we) arm_ff <= arm_ff + 32'd1;
         if (add_do) begin
            head_ff          <= (head_ff == W'(MAX_SLOTS - 1)) ? '0 : head_ff + 1'b1;
            nfree_ff         <= nfree_ff - 1'b1;
            used_ff[add_idx] <= 1'b1;
         end
         if (rel) begin
            tail_ff          <= (tail_ff == W'(MAX_SLOTS - 1)) ? '0 : tail_ff + 1'b1;
            nfree_ff         <= nfree_ff + 1'b1;
            used_ff[rel_idx] <= 1'b0;
            qval_ff[tail_ff] <= 1'b1;
         end
      end
   end

   // latched command
   always_ff @(posedge clock) begin
      if (pop) cmd_ff <= cmd;
   end

   // scan for the earliest expired slot
   always_ff @(posedge clock) begin
      if (reset) begin
         scnt_ff  <= '0;
         dval_ff  <= 1'b0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         if (scan_start) begin
            scnt_ff  <= '0;
            dval_ff  <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            dval_ff <= scan_issue;
            if (scan_issue) scnt_ff <= scnt_ff + 1'b1;
            if (hit) found_ff <= 1'b1;
         end
         if (pend_load) pend_ff <= 1'b1;
         else if (pend_clr) pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) didx_ff <= scnt_ff[W-1:0];
      if (hit && !scan_start) begin
         best_ff  <= didx_ff;
         bexp_ff  <= e_rd_ff;
         bkey_ff  <= key;
         bhand_ff <= h_rd_ff;
      end
      if (pend_load) begin
         pidx_ff  <= best_ff;
         phand_ff <= bhand_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (emit) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ostat_ff <= e_stat;
         oid_ff   <= e_id;
         ohand_ff <= e_hand;
         oexp_ff  <= e_exp;
         olast_ff <= e_last;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'd0, ohand_ff, oid_ff, ostat_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = oexp_ff;

endmodule
`default_nettype wire

### rtl/connection_slot_timeout_table_unit.sv
// Connection slot table with expiry timers.
// req channel: tuser carries the function (add, delete, refresh, get, check),
// tdata the handle, id, timeout and current time. rsp channel: tdata carries
// status, id and handle, tuser the expired flag, tlast the final result of a
// request. csr channel writes the 8-bit group prefix placed in every id.
// Requests enter a two-entry command queue and are carried out one at a time
// by a sequencer around single-port slot memories.
// Delete, refresh and errors go to the result register straight from idle;
// add and get first pass one registered memory read (ADD_WR, GET_WR states).
// A check scans all MAX_SLOTS slots once per expired slot it reports and once
// more to find none left, a slot at a time through the one read port of the
// expiry and stamp memories.
// Results wait in an output register; while the receiver stalls the
// sequencer holds at its next result and the queue takes up to two requests.
// Reset empties the table, refills the free list with all slots in order,
// and clears the prefix to zero; no clearing pass is needed.
`default_nettype none
module connection_slot_timeout_table_unit #(
   parameter int MAX_SLOTS = cstt_pkg::MAX_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // conn_handle, conn_id, timeout_ms, now_ms
   input  wire logic [2:0]   req_tuser,  // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,  // status, id_out, handle_out, zero pad
   output logic              rsp_tlast,
   output logic              rsp_tuser,  // expired
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   logic [7:0]        prefix_ff;
   logic              cmd_valid, cmd_ready;
   cstt_pkg::cmd_type cmd;

   // group prefix register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 8'd0;
      end else if (csr_valid) begin
         prefix_ff <= csr_data;
      end
   end

   cstt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   cstt_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .prefix     (prefix_ff),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### tb/slot_table_checker.sv
`default_nettype none
module slot_table_checker #(
   parameter int SLOTS = cstt_pkg::MAX_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,  // conn_handle, conn_id, timeout_ms, now_ms
   input  wire logic [2:0]   req_tuser,  // func
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [71:0]  rsp_tdata,  // status, id_out, handle_out, zero pad
   input  wire logic         rsp_tlast,
   input  wire logic         rsp_tuser,  // expired
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [7:0]   csr_data,
   output int                pending,
   output int                fail_count
);

   localparam int DEPTH = 256;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] id;
      logic [31:0] handle;
      logic        expired;
      logic        last;
   } slot_result_type;

   // shadow of the table
   logic [31:0] slot_handle [SLOTS];
   logic        slot_busy   [SLOTS];
   logic [31:0] slot_expiry [SLOTS];
   logic [31:0] slot_stamp  [SLOTS];
   logic [31:0] arm_count;
   int          free_list   [SLOTS];
   int          free_head;
   int          free_tail;
   int          free_count;
   logic [7:0]  prefix_reg;

   // ring of expected results
   slot_result_type expect_buf [DEPTH];
   int              exp_rd;
   int              exp_wr;
   int              exp_cnt;
   int              fails = 0;

   assign pending    = exp_cnt;
   assign fail_count = fails;

   function automatic slot_result_type make_result(logic [2:0] st, logic [31:0] id,
                                                   logic [31:0] h, logic ex, logic lst);
      slot_result_type r;
      r.status  = st;
      r.id      = id;
      r.handle  = h;
      r.expired = ex;
      r.last    = lst;
      return r;
   endfunction

   task automatic store_expect(slot_result_type r);
      expect_buf[exp_wr] = r;
      exp_wr             = (exp_wr + 1) % DEPTH;
      exp_cnt            = exp_cnt + 1;
   endtask

   task automatic arm_slot(int idx, logic [31:0] expiry);
      slot_expiry[idx] = expiry;
      slot_stamp[idx]  = arm_count;
      arm_count        = arm_count + 1;
   endtask

   task automatic free_slot(int idx);
      slot_busy[idx]        = 1'b0;
      slot_handle[idx]      = '0;
      free_list[free_tail]  = idx;
      free_tail             = (free_tail + 1) % SLOTS;
      free_count            = free_count + 1;
   endtask

   // work out the results of one request and update the shadow table
   task automatic predict_request(logic [2:0] fn, logic [31:0] h, logic [31:0] id,
                                  logic [31:0] tmo, logic [31:0] now);
      int          idx;
      int          best;
      int          n;
      logic [2:0]  st;
      logic [31:0] h_out;
      logic [31:0] bexp;
      logic [31:0] bkey;
      logic [31:0] key;
      bit          found;
      idx = 0;
      n = 0;
      if (fn == cstt_pkg::FUNC_ADD) begin
         if (free_count == 0) begin
            store_expect(make_result(cstt_pkg::STAT_FULL, '0, '0, 1'b0, 1'b1));
         end else begin
            idx = free_list[free_head];
            free_head = (free_head + 1) % SLOTS;
            free_count = free_count - 1;
            slot_busy[idx] = 1'b1;
            slot_handle[idx] = h;
            arm_slot(idx, now + tmo);
            store_expect(make_result(cstt_pkg::STAT_OK,
               {prefix_reg, 24'(idx)}, '0, 1'b0, 1'b1));
         end
      end else if (fn == cstt_pkg::FUNC_DELETE || fn == cstt_pkg::FUNC_REFRESH ||
                   fn == cstt_pkg::FUNC_GET) begin
         h_out = '0;
         idx = int'(id[23:0]);
         if (id[31:24] != prefix_reg) begin
            st = cstt_pkg::STAT_PREFIX;
         end else if (idx >= SLOTS) begin
            st = cstt_pkg::STAT_RANGE;
         end else if (!slot_busy[idx]) begin
            st = cstt_pkg::STAT_UNUSED;
         end else begin
            st = cstt_pkg::STAT_OK;
            if (fn == cstt_pkg::FUNC_DELETE) free_slot(idx);
            else if (fn == cstt_pkg::FUNC_REFRESH) arm_slot(idx, now + tmo);
            else h_out = slot_handle[idx];
         end
         store_expect(make_result(st, '0, h_out, 1'b0, 1'b1));
      end else if (fn == cstt_pkg::FUNC_CHECK) begin
         // pick the earliest expiry, oldest arming first, until none is due
         do begin
            found = 0;
            best = 0;
            bexp = '0;
            bkey = '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i] && slot_expiry[i] <= now) begin
                  key = slot_stamp[i] - arm_count;
                  if (!found || slot_expiry[i] < bexp ||
                      (slot_expiry[i] == bexp && key < bkey)) begin
                     found = 1;
                     best = i;
                     bexp = slot_expiry[i];
                     bkey = key;
                  end
               end
            end
            if (found) begin
               store_expect(make_result(cstt_pkg::STAT_OK,
                  {prefix_reg, 24'(best)}, slot_handle[best], 1'b1, 1'b0));
               n++;
               free_slot(best);
            end
         end while (found);
         if (n == 0) store_expect(make_result(cstt_pkg::STAT_OK, '0, '0, 1'b0, 1'b1));
         else expect_buf[(exp_wr + DEPTH - 1) % DEPTH].last = 1'b1;
      end else begin
         store_expect(make_result(cstt_pkg::STAT_OK, '0, '0, 1'b0, 1'b1));
      end
   endtask

   // watch all three channels at the clock edge
   always @(posedge clock) begin
      slot_result_type got;
      slot_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_handle[i] = '0;
            slot_busy[i]   = 1'b0;
            slot_expiry[i] = '0;
            slot_stamp[i]  = '0;
            free_list[i]   = i;
         end
         arm_count = '0;
         free_head = 0;
         free_tail = 0;
         free_count = SLOTS;
         prefix_reg = '0;
         exp_rd = 0;
         exp_wr = 0;
         exp_cnt = 0;
      end else begin
         // compare an outgoing transfer with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = make_result(rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[66:35],
                              rsp_tuser, rsp_tlast);
            if (exp_cnt == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result: status %0d id %h handle %h exp %b last %b",
                           got.status, got.id, got.handle, got.expired, got.last);
            end else begin
               want = expect_buf[exp_rd];
               exp_rd = (exp_rd + 1) % DEPTH;
               exp_cnt = exp_cnt - 1;
               if (got !== want) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch: want st %0d id %h h %h exp %b last %b",
                              want.status, want.id, want.handle, want.expired,
                              want.last);
                     $display("          got  st %0d id %h h %h exp %b last %b",
                              got.status, got.id, got.handle, got.expired, got.last);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) prefix_reg = csr_data;
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[31:0], req_tdata[63:32],
                            req_tdata[95:64], req_tdata[127:96]);
      end
   end

endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // conn_handle, conn_id, timeout_ms, now_ms
   logic [2:0]   req_tuser = '0;  // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;       // status, id_out, handle_out, zero pad
   logic         rsp_tlast;
   logic         rsp_tuser;       // expired
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   int           pending;
   int           fail_count;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           hold_go = 0;
   bit           hold_used = 0;
   int           hold_left = 0;
   logic [7:0]   prefix = '0;
   logic [31:0]  clock_ms = '0;

   always #1 clock = ~clock;

   connection_slot_timeout_table_unit i_dut (.*);

   slot_table_checker i_checker (.*);

   // receiver side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_go && !hold_used) begin
         hold_left <= 300;
         hold_used <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_request(logic [2:0] fn, logic [31:0] h, logic [31:0] id,
                               logic [31:0] tmo, logic [31:0] now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {now, tmo, id, h};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_prefix(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      prefix = value;
   endtask

   function automatic logic [31:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return {prefix, 24'($urandom_range(0, 63))};
      if (r < 90) return {prefix, 24'($urandom)};
      if (r < 95) return {prefix ^ 8'($urandom_range(1, 255)), 24'($urandom_range(0, 63))};
      return $urandom;
   endfunction

   // mixed traffic with a slowly advancing clock so that checks find work
   task automatic random_traffic(int count);
      int          r;
      logic [31:0] tmo;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         clock_ms = clock_ms + $urandom_range(0, 40);
         tmo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
         if (r < 32)
            send_request(cstt_pkg::FUNC_ADD, $urandom, $urandom, tmo, clock_ms);
         else if (r < 47)
            send_request(cstt_pkg::FUNC_DELETE, $urandom, pick_id(), $urandom, clock_ms);
         else if (r < 62)
            send_request(cstt_pkg::FUNC_REFRESH, $urandom, pick_id(), tmo, clock_ms);
         else if (r < 77)
            send_request(cstt_pkg::FUNC_GET, $urandom, pick_id(), $urandom, clock_ms);
         else if (r < 94)
            send_request(cstt_pkg::FUNC_CHECK, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 19) == 0) ? $urandom : clock_ms);
         else
            send_request(3'($urandom_range(5, 7)), $urandom, $urandom,
                         $urandom, $urandom);
      end
   endtask

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every function, errors and tie ordering
      send_request(cstt_pkg::FUNC_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      send_request(cstt_pkg::FUNC_ADD, 32'h1234_5678, 32'h0, 32'd10, 32'd5);
      send_request(cstt_pkg::FUNC_GET, 32'h0, 32'h0000_0000, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_GET, 32'h0, 32'h0000_0001, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_REFRESH, 32'h0, 32'h0000_0002, 32'h0, 32'd3);
      send_request(cstt_pkg::FUNC_DELETE, 32'h0, 32'h0000_0000, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_GET, 32'h0, 32'h0000_0000, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_GET, 32'h0, 32'hFF00_0001, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_DELETE, 32'h0, 32'h0000_0040, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_REFRESH, 32'h0, 32'h00FF_FFFF, 32'h0, 32'h0);
      send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(3'd6, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(cstt_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0, 32'd3);
      send_request(cstt_pkg::FUNC_ADD, 32'hAAAA_5555, 32'h0, 32'd0, 32'd100);
      send_request(cstt_pkg::FUNC_ADD, 32'h5555_AAAA, 32'h0, 32'd0, 32'd100);
      send_request(cstt_pkg::FUNC_REFRESH, 32'h0, 32'h0000_0003, 32'd0, 32'd100);
      send_request(cstt_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0, 32'd100);
      send_request(cstt_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               write_prefix(8'hFF);
            end
            1: begin
               send_idle_pct = 48; recv_stall_pct = 0;
               write_prefix(8'($urandom_range(1, 254)));
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 48;
               write_prefix(8'h00);
            end
            default: begin
               send_idle_pct = 26; recv_stall_pct = 26;
               write_prefix(8'($urandom));
            end
         endcase
         if (phase == 0) begin
            // fill the table past full, then sweep it out near the top of time
            for (int k = 0; k < 66; k++)
               send_request(cstt_pkg::FUNC_ADD, $urandom, 32'h0,
                            32'h1000 + $urandom_range(0, 3), 32'hFFFF_E000);
            send_request(cstt_pkg::FUNC_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
         end
         if (phase == 2) hold_go = 1;
         random_traffic(96);
         drain_results();
      end

      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
